// ===== sv/rtt_pkg.sv =====
// Reaction time tester: shared types, codes and reset constants.
// No dependencies; used by every module of the block.
`default_nettype none

package rtt_pkg;

  // Elapsed counter width, default for the top-level parameter
  localparam int COUNT_WIDTH_DEF = 16;

  // Register reset values
  localparam logic [1:0]  MODE_RST       = 2'd0;
  localparam logic [15:0] TIMEOUT_RST    = 16'd2000;
  localparam logic [15:0] SPEAKER_RST    = 16'd500;
  localparam logic [7:0]  DEBOUNCE_RST   = 8'd10;
  localparam logic [15:0] BASE_DELAY_RST = 16'd10000;

  // Register indexes on the config port
  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_TIMEOUT    = 3'd1;
  localparam logic [2:0] REG_SPEAKER    = 3'd2;
  localparam logic [2:0] REG_DEBOUNCE   = 3'd3;
  localparam logic [2:0] REG_BASE_DELAY = 3'd4;

  // Mode codes
  localparam logic [1:0] MODE_CAR  = 2'd0;
  localparam logic [1:0] MODE_BIKE = 2'd1;
  localparam logic [1:0] MODE_HORN = 2'd2;
  // Spare code: arms nothing, no phase rules, counters still run
  localparam logic [1:0] MODE_NONE = 2'd3;

  // Bit positions in the pin / debounced level vectors
  localparam int LV_ACCEL = 0;
  localparam int LV_BRAKE = 1;
  localparam int LV_HORN  = 2;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ARMED  = 3'd2,
    PH_WAIT   = 3'd3,
    PH_TIMING = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    OUT_NONE     = 2'd0,
    OUT_FALSE    = 2'd1,
    OUT_TIMEOUT  = 2'd2,
    OUT_MEASURED = 2'd3
  } outcome_t;

  // One tick as held in the input register
  typedef struct packed {
    logic [2:0]  pins;        // active low, LV_* positions
    logic        start_trial;
    logic        end_session;
    logic [11:0] random_draw;
  } tick_t;

  // Configuration registers
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] timeout_ms;
    logic [15:0] speaker_ms;
    logic [7:0]  debounce_ms;
    logic [15:0] base_delay_ms;
  } cfg_t;

  // Result of one tick
  typedef struct packed {
    logic        red_lamp;
    logic        green_lamp;
    logic        speaker_on;
    outcome_t    outcome;
    logic [15:0] reaction_ms;
    logic [7:0]  false_start_count;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/rtt_debounce.sv =====
// Shared debounce counter for the three pins, served in priority order
// accelerator, brake, horn. Depends on rtt_pkg.
`default_nettype none

module rtt_debounce (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire rtt_pkg::tick_t tick,
  input  wire logic [7:0]    debounce_ms,
  output logic [2:0]         levels
);

  logic [7:0] count, count_next;
  logic [2:0] levels_next;
  logic [2:0] diff;
  logic [1:0] sel;

  assign diff = tick.pins ^ levels;

  always_comb begin
    levels_next = levels;
    count_next  = count;
    sel         = 2'(rtt_pkg::LV_ACCEL);
    priority if (diff[rtt_pkg::LV_ACCEL]) sel = 2'(rtt_pkg::LV_ACCEL);
    else if (diff[rtt_pkg::LV_BRAKE])     sel = 2'(rtt_pkg::LV_BRAKE);
    else                                  sel = 2'(rtt_pkg::LV_HORN);
    if (tick.end_session || diff == 3'b000) begin
      count_next = debounce_ms;
    end else if (count <= 8'd1) begin
      count_next       = debounce_ms;
      levels_next[sel] = tick.pins[sel];
    end else begin
      count_next = count - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= 3'b111;
      count  <= rtt_pkg::DEBOUNCE_RST;
    end else if (step) begin
      levels <= levels_next;
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rtt_trial.sv =====
// Trial sequencer: arm, random wait, cue, response timing, outcome and
// false-start tally. Depends on rtt_pkg.
`default_nettype none

module rtt_trial #(
  parameter int COUNT_WIDTH = rtt_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire rtt_pkg::tick_t  tick,
  input  wire rtt_pkg::cfg_t   cfg,
  input  wire logic [2:0]      levels,
  output rtt_pkg::result_t     result
);

  localparam int RW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] EL_MAX = {COUNT_WIDTH{1'b1}};

  rtt_pkg::phase_t phase, phase_next;
  logic [15:0] delay_count, delay_count_next;
  logic        delay_active, delay_active_next;
  logic [COUNT_WIDTH-1:0] elapsed, elapsed_next;
  logic        timing_active, timing_active_next;
  logic [15:0] speaker_count, speaker_count_next;
  logic        red_on, red_on_next;
  logic        green_on, green_on_next;
  logic [7:0]  tally, tally_next;

  logic [16:0] wait_sum;
  logic [15:0] wait_len;
  logic [RW-1:0] el_wide;
  logic        resp_pressed;
  logic        early;

  assign wait_sum = {1'b0, cfg.base_delay_ms} + 17'(tick.random_draw);
  assign wait_len = wait_sum[16] ? 16'hFFFF : wait_sum[15:0];
  assign el_wide  = RW'(elapsed);
  assign resp_pressed = (cfg.mode == rtt_pkg::MODE_CAR) ? !levels[rtt_pkg::LV_BRAKE]
                                                        : !levels[rtt_pkg::LV_HORN];
  // Leaving the accelerator (car) or touching the horn before the cue
  assign early = (cfg.mode == rtt_pkg::MODE_CAR) ? levels[rtt_pkg::LV_ACCEL]
                                                 : !levels[rtt_pkg::LV_HORN];

  always_comb begin
    phase_next         = phase;
    delay_count_next   = delay_count;
    delay_active_next  = delay_active;
    elapsed_next       = elapsed;
    timing_active_next = timing_active;
    speaker_count_next = speaker_count;
    red_on_next        = red_on;
    green_on_next      = green_on;
    tally_next         = tally;
    result.outcome     = rtt_pkg::OUT_NONE;
    result.reaction_ms = 16'd0;
    result.speaker_on  = 1'b0;

    if (tick.end_session) begin
      phase_next         = rtt_pkg::PH_IDLE;
      delay_active_next  = 1'b0;
      timing_active_next = 1'b0;
      speaker_count_next = 16'd0;
      red_on_next        = 1'b0;
      green_on_next      = 1'b0;
    end else begin
      // arm
      if (tick.start_trial && phase == rtt_pkg::PH_IDLE) begin
        if (cfg.mode == rtt_pkg::MODE_CAR) begin
          phase_next    = rtt_pkg::PH_ARMED;
          green_on_next = 1'b1;
        end else if (cfg.mode == rtt_pkg::MODE_BIKE || cfg.mode == rtt_pkg::MODE_HORN) begin
          phase_next        = rtt_pkg::PH_WAIT;
          delay_count_next  = wait_len;
          delay_active_next = 1'b1;
          if (cfg.mode == rtt_pkg::MODE_BIKE) green_on_next = 1'b1;
        end
      end

      // phase rules, not applied in the unused mode code
      if (cfg.mode != rtt_pkg::MODE_NONE) begin
        unique case (phase_next)
          rtt_pkg::PH_ARMED: begin
            if (cfg.mode == rtt_pkg::MODE_CAR && !levels[rtt_pkg::LV_ACCEL]) begin
              phase_next        = rtt_pkg::PH_WAIT;
              delay_count_next  = wait_len;
              delay_active_next = 1'b1;
            end
          end
          rtt_pkg::PH_WAIT: begin
            if (!delay_active_next) begin
              elapsed_next       = '0;
              timing_active_next = 1'b1;
              phase_next         = rtt_pkg::PH_TIMING;
              if (cfg.mode == rtt_pkg::MODE_HORN) begin
                speaker_count_next = cfg.speaker_ms;
              end else begin
                green_on_next = 1'b0;
                red_on_next   = 1'b1;
              end
            end else if (early) begin
              if (tally != 8'hFF) tally_next = tally + 8'd1;
              phase_next     = rtt_pkg::PH_IDLE;
              result.outcome = rtt_pkg::OUT_FALSE;
              if (cfg.mode != rtt_pkg::MODE_HORN) green_on_next = 1'b0;
            end
          end
          rtt_pkg::PH_TIMING: begin
            if (el_wide > RW'(cfg.timeout_ms) || elapsed == EL_MAX) begin
              timing_active_next = 1'b0;
              phase_next         = rtt_pkg::PH_IDLE;
              result.outcome     = rtt_pkg::OUT_TIMEOUT;
              if (cfg.mode != rtt_pkg::MODE_HORN) red_on_next = 1'b0;
            end else if (resp_pressed) begin
              timing_active_next = 1'b0;
              phase_next         = rtt_pkg::PH_IDLE;
              result.outcome     = rtt_pkg::OUT_MEASURED;
              result.reaction_ms = (el_wide > RW'(16'hFFFF)) ? 16'hFFFF : el_wide[15:0];
              if (cfg.mode != rtt_pkg::MODE_HORN) red_on_next = 1'b0;
            end
          end
          default: ;
        endcase
      end

      if (timing_active_next && elapsed_next != EL_MAX) begin
        elapsed_next = elapsed_next + COUNT_WIDTH'(1);
      end

      if (delay_active_next) begin
        if (delay_count_next <= 16'd1) begin
          delay_count_next  = 16'd0;
          delay_active_next = 1'b0;
        end else begin
          delay_count_next = delay_count_next - 16'd1;
        end
      end

      if (speaker_count_next != 16'd0) begin
        speaker_count_next = speaker_count_next - 16'd1;
        result.speaker_on  = 1'b1;
      end
    end

    result.red_lamp          = red_on_next;
    result.green_lamp        = green_on_next;
    result.false_start_count = tally_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= rtt_pkg::PH_IDLE;
      delay_count   <= 16'd0;
      delay_active  <= 1'b0;
      elapsed       <= '0;
      timing_active <= 1'b0;
      speaker_count <= 16'd0;
      red_on        <= 1'b0;
      green_on      <= 1'b0;
      tally         <= 8'd0;
    end else if (step) begin
      phase         <= phase_next;
      delay_count   <= delay_count_next;
      delay_active  <= delay_active_next;
      elapsed       <= elapsed_next;
      timing_active <= timing_active_next;
      speaker_count <= speaker_count_next;
      red_on        <= red_on_next;
      green_on      <= green_on_next;
      tally         <= tally_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/reaction_time_tester_core.sv =====
// Reaction time tester top level: stream ports, config registers, input and
// result registers. Depends on rtt_pkg, rtt_debounce and rtt_trial.
//
// Usage:
//  - Each item on the s_axis channel is one 1 ms tick: three raw active-low
//    pins, start/end flags and a 12-bit random draw for the cue delay.
//  - Every tick produces exactly one result item on m_axis: lamps, speaker,
//    outcome code, reaction time and the saturating false-start count.
//  - Config writes (cfg_valid/cfg_ready, cfg_index, cfg_data) go to mode,
//    timeout, speaker pulse length, debounce length and base delay. They
//    are always taken; write them only with no tick in flight.
//  - Path: an accepted tick passes the input register, one pass of logic and
//    the result register before its result shows on m_axis.
//  - Throughput: one tick per clock while m_axis does not stall. s_axis_tready
//    stays high while the result register is empty or being drained in the same cycle.
//  - Receiver stall: the result holds in the output register; one more tick
//    waits in the input register, then s_axis_tready drops. State only
//    advances when a tick moves into the result register.
//  - Reset (rst, synchronous): registers return to their defaults, phase
//    idle, pins released, trial counters and tally cleared, both channels empty.
`default_nettype none

module reaction_time_tester_core #(
  parameter int COUNT_WIDTH = rtt_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input ticks
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] accel_pin, [1] brake_pin, [2] horn_pin, [3] start_trial,
  // [4] end_session, [16:5] random_draw, [23:17] zero
  input  wire logic [23:0] s_axis_tdata,
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] red_lamp, [1] green_lamp, [2] speaker_on, [4:3] outcome,
  // [20:5] reaction_ms, [28:21] false_start_count, [31:29] zero
  output logic [31:0]      m_axis_tdata,
  // config writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  rtt_pkg::cfg_t    cfg;
  rtt_pkg::tick_t   tick;
  rtt_pkg::result_t result;
  logic             in_valid;
  logic             step;
  logic [2:0]       levels;

  // Tick is evaluated when the result register is free or draining
  assign step          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;
  assign cfg_ready     = 1'b1;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode          <= rtt_pkg::MODE_RST;
      cfg.timeout_ms    <= rtt_pkg::TIMEOUT_RST;
      cfg.speaker_ms    <= rtt_pkg::SPEAKER_RST;
      cfg.debounce_ms   <= rtt_pkg::DEBOUNCE_RST;
      cfg.base_delay_ms <= rtt_pkg::BASE_DELAY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rtt_pkg::REG_MODE:       cfg.mode          <= cfg_data[1:0];
        rtt_pkg::REG_TIMEOUT:    cfg.timeout_ms    <= cfg_data;
        rtt_pkg::REG_SPEAKER:    cfg.speaker_ms    <= cfg_data;
        rtt_pkg::REG_DEBOUNCE:   cfg.debounce_ms   <= cfg_data[7:0];
        rtt_pkg::REG_BASE_DELAY: cfg.base_delay_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      tick.pins        <= s_axis_tdata[2:0];
      tick.start_trial <= s_axis_tdata[3];
      tick.end_session <= s_axis_tdata[4];
      tick.random_draw <= s_axis_tdata[16:5];
    end
  end

  rtt_debounce u_debounce (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .tick        (tick),
    .debounce_ms (cfg.debounce_ms),
    .levels      (levels)
  );

  rtt_trial #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_trial (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .tick   (tick),
    .cfg    (cfg),
    .levels (levels),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_axis_tdata <= {3'b000, result.false_start_count, result.reaction_ms,
                       result.outcome, result.speaker_on, result.green_lamp,
                       result.red_lamp};
    end
  end

endmodule

`default_nettype wire
